// ===== rtl/sha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, shared types and round helpers.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int ROUND_COUNT_DEF = 64;
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } byte_item_type;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_PAD,
      ST_LENGTH,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } back_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage : sha_pkg
`default_nettype wire

// ===== rtl/sha_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA item queue
// Short queue between the byte intake and the compression engine.
// ----------------------------------------------------------------------------
module sha_queue
   import sha_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire byte_item_type push_item,
   output logic               full,
   input  wire logic          pop,
   output byte_item_type      pop_item,
   output logic               empty
);
   localparam int AW = $clog2(QUEUE_DEPTH);

   byte_item_type     mem [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;

   assign full     = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) count_in = count_ff + 1'b1;
      if (!(push && !full) && (pop && !empty)) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      full |=> !(count_ff == '0)) else $error("full queue drained without pop");
   a_ptr_sync: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff)) else $error("pointer mismatch");
`endif

endmodule : sha_queue
`default_nettype wire

// ===== rtl/sha_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA engine
// Block buffer, padding sequencer, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha_engine
   import sha_pkg::*;
#(
   parameter int ROUND_COUNT = ROUND_COUNT_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire byte_item_type item,
   input  wire logic          item_valid,
   output logic               item_take,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [31:0]        rsp_digest_word,
   output logic [2:0]         rsp_word_index,
   output logic               rsp_last_word
);
   localparam int PW = $clog2(BLOCK_BYTES);
   localparam int RW = $clog2(ROUND_COUNT);

   back_state_type  state_ff, state_in;
   logic [31:0]     h_ff [8];
   logic [31:0]     v_ff [8];
   logic [31:0]     w_ff [16];
   logic [60:0]     total_ff;
   logic [PW-1:0]   fill_ff;
   logic [RW-1:0]   round_ff;
   logic [2:0]      out_ff;
   logic            final_ff;   // compression belongs to message end
   logic            len_next_ff; // after this compress, length block follows
   logic            pad_next_ff; // full last block done, padding block follows

   // round datapath
   logic [31:0] t1, t2, s0, s1, w_new, w_cur;
   always_comb begin
      w_cur = w_ff[0];
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(round_ff) + w_cur;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign item_take       = (state_ff == ST_ACCEPT) && item_valid;
   assign rsp_empty       = (state_ff != ST_EMIT);
   assign rsp_digest_word = h_ff[out_ff];
   assign rsp_word_index  = out_ff;
   assign rsp_last_word   = (out_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (item_take) begin
               if (item.byte_valid && (fill_ff == PW'(BLOCK_BYTES - 1)))
                  state_in = ST_ROUND;
               else if (item.last_byte)
                  state_in = ST_PAD;
            end
         end
         ST_PAD:    state_in = (fill_ff >= PW'(BLOCK_BYTES - 8)) ? ST_ROUND : ST_LENGTH;
         ST_LENGTH: state_in = ST_ROUND;
         ST_ROUND:  if (round_ff == RW'(ROUND_COUNT - 1)) state_in = ST_FOLD;
         ST_FOLD: begin
            if (len_next_ff)      state_in = ST_LENGTH;
            else if (pad_next_ff) state_in = ST_PAD;
            else if (final_ff)    state_in = ST_EMIT;
            else                  state_in = ST_ACCEPT;
         end
         ST_EMIT:   if (rsp_pop && out_ff == 3'd7) state_in = ST_ACCEPT;
         default:   state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= reset ? ST_ACCEPT : state_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
         for (int j = 0; j < 16; j++) w_ff[j] <= '0;
         total_ff <= '0;
         fill_ff  <= '0;
         out_ff   <= '0;
      end else begin
         case (state_ff)
            ST_ACCEPT: begin
               if (item_take) begin
                  if (item.byte_valid) begin
                     w_ff[fill_ff[PW-1:2]][8*(3-fill_ff[1:0]) +: 8] <= item.data_byte;
                     total_ff <= total_ff + 61'd1;
                     fill_ff  <= fill_ff + 1'b1;
                  end
                  final_ff    <= item.last_byte;
                  len_next_ff <= 1'b0;
                  pad_next_ff <= item.byte_valid && item.last_byte
                                 && (fill_ff == PW'(BLOCK_BYTES - 1));
                  round_ff    <= '0;
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               end
            end
            ST_PAD: begin
               for (int j = 0; j < 16; j++) begin
                  for (int b = 0; b < 4; b++) begin
                     if (PW'(4*j+b) == fill_ff)     w_ff[j][8*(3-b) +: 8] <= PAD_BYTE;
                     else if (PW'(4*j+b) > fill_ff) w_ff[j][8*(3-b) +: 8] <= 8'h00;
                  end
               end
               len_next_ff <= (fill_ff >= PW'(BLOCK_BYTES - 8));
               pad_next_ff <= 1'b0;
               round_ff    <= '0;
            end
            ST_LENGTH: begin
               w_ff[14]    <= total_ff[60:29];
               w_ff[15]    <= {total_ff[28:0], 3'b000};
               len_next_ff <= 1'b0;
               round_ff    <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_ROUND: begin
               for (int j = 0; j < 15; j++) w_ff[j] <= w_ff[j+1];
               w_ff[15] <= w_new;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 1'b1;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               // buffer starts clear for the next block
               for (int j = 0; j < 16; j++) w_ff[j] <= '0;
               out_ff <= '0;
            end
            ST_EMIT: begin
               if (rsp_pop) begin
                  out_ff <= out_ff + 1'b1;
                  if (out_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
                     total_ff <= '0;
                     fill_ff  <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_take_only_accept: assert property (@(posedge clock) disable iff (reset)
      item_take |-> (state_ff == ST_ACCEPT)) else $error("take outside accept");
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_pop && out_ff != 3'd7) |=> (state_ff == ST_EMIT))
      else $error("digest cut short");
   a_fold_after_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> $past(state_ff == ST_ROUND)) else $error("bad fold");
`endif

endmodule : sha_engine
`default_nettype wire

// ===== rtl/sha256_hash_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hash core
// Byte-serial SHA-256: bytes in, eight digest words out per message.
// ----------------------------------------------------------------------------
// channel   dir  handshake     fields
// req_      in   push / full   data_byte, byte_valid, last_byte
// rsp_      out  empty / pop   digest_word, word_index, last_word
//
// A byte item is taken from the queue while the engine is accepting; the 64th byte
// of a block starts its rounds and fold, run by the single shared round unit.
// Message end: pad, optional extra block, length, rounds;
// a last item that fills a block first runs that block, then pads.
// Reset is synchronous; the core restarts from the initial hash values.
// The 4-entry queue absorbs up to four items while the engine compresses or
// waits on pop; after that full stays high until the engine takes again.
module sha256_hash_core
   import sha_pkg::*;
#(
   parameter int ROUND_COUNT = ROUND_COUNT_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_last_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   byte_item_type in_item, q_item;
   logic          q_empty, q_take;

   assign in_item = '{data_byte: req_data_byte, byte_valid: req_byte_valid,
                      last_byte: req_last_byte};

   sha_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(in_item), .full(full),
      .pop(q_take), .pop_item(q_item), .empty(q_empty)
   );

   sha_engine #(.ROUND_COUNT(ROUND_COUNT), .BLOCK_BYTES(BLOCK_BYTES)) u_engine (
      .clock(clock), .reset(reset),
      .item(q_item), .item_valid(!q_empty), .item_take(q_take),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

`ifndef SYNTH
   a_idx_last: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last flag mismatch");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_word) |=> (!empty &&
      rsp_word_index == $past(rsp_word_index) + 3'd1)) else $error("index skip");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_digest_word)) else $error("word changed");
`endif

endmodule : sha256_hash_core
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash core testbench
// Feeds byte items (valid, invalid, last) through the push/full side and
// compares every digest word popped from the result side against a
// predictor that runs its own byte-serial SHA-256. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import sha_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   // Digest predictor and store of expected digest words.
   class digest_scoreboard;
      logic [31:0] chain [8];
      logic [31:0] block_words [16];
      logic [60:0] byte_count;
      logic [5:0]  fill;
      digest_item_type pending_words [$];
      int errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = init_h(i[2:0]);
         for (int i = 0; i < 16; i++) block_words[i] = '0;
         byte_count = '0;
         fill = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void place_byte(int pos, logic [7:0] b);
         int sh;
         sh = 24 - 8 * (pos % 4);
         block_words[pos / 4] = (block_words[pos / 4] & ~(32'hff << sh))
                              | ({24'h0, b} << sh);
      endfunction

      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) w[i] = block_words[i];
         for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] += v[i];
         for (int i = 0; i < 16; i++) block_words[i] = '0;
      endfunction

      // Note one accepted byte item.
      function void note_item(logic [7:0] data, logic valid, logic last);
         logic [63:0] bit_len;
         digest_item_type d;
         if (valid) begin
            place_byte(fill, data);
            byte_count++;
            fill++;
            if (fill == 0) compress_block();
         end
         if (!last) return;
         place_byte(fill, PAD_BYTE);
         for (int p = fill + 1; p < 64; p++) place_byte(p, 8'h00);
         if (fill >= 56) compress_block();
         bit_len = {byte_count, 3'b000};
         block_words[14] = bit_len[63:32];
         block_words[15] = bit_len[31:0];
         compress_block();
         for (int k = 0; k < 8; k++) begin
            d.word = chain[k];
            d.index = k[2:0];
            d.last = (k == 7);
            pending_words.push_back(d);
         end
         restart();
      endfunction

      // Check one popped digest word against the oldest expectation.
      function void check_word(digest_item_type got);
         digest_item_type exp_w;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected digest word %h", $time, got);
            errors++;
            return;
         end
         exp_w = pending_words.pop_front();
         if (got.word !== exp_w.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, exp_w.word, got.word);
            errors++;
         end
         if (got.index !== exp_w.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, exp_w.index, got.index);
            errors++;
         end
         if (got.last !== exp_w.last) begin
            $display("%0t: last_word expected %b actual %b", $time, exp_w.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_valid = 0;
   logic        req_last_byte = 0;
   logic        pop = 0;
   logic        full, empty;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard sb = new();
   int  cycle_count = 0;
   bit  pop_hold = 0;   // stretches where the reader stalls

   always #5 clock = ~clock;

   sha256_hash_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_byte_valid(req_byte_valid),
      .req_last_byte(req_last_byte), .empty(empty), .pop(pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Push one byte item, hold until accepted, then note it.
   // push stays high after acceptance; callers drop it before idling.
   task automatic send_item(logic [7:0] data, logic valid, logic last, bit hold_off);
      int idle;
      idle = hold_off ? gap_len() : 0;
      if (idle > 0) begin
         push <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= data;
      req_byte_valid <= valid;
      req_last_byte <= last;
      do @(posedge clock); while (full);
      sb.note_item(data, valid, last);
   endtask

   // Message of n bytes ending on last; the final byte may ride on last or not.
   task automatic send_message(int n, bit sprinkle_idle, bit hold_off);
      bit tail_on_last;
      tail_on_last = (n > 0) && $urandom_range(0, 1);
      for (int i = 0; i < n - (tail_on_last ? 1 : 0); i++) begin
         if (sprinkle_idle && $urandom_range(0, 9) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, hold_off);
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, hold_off);
      end
      send_item(8'($urandom_range(0, 255)), tail_on_last, 1'b1, hold_off);
   endtask

   // Reader: pop at random, check each accepted word.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            sb.check_word({rsp_digest_word, rsp_word_index, rsp_last_word});
         pop <= pop_hold ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
   end

   // Occasional long reader stalls.
   initial begin
      forever begin
         repeat ($urandom_range(50, 400)) @(posedge clock);
         pop_hold <= 1'b1;
         repeat ($urandom_range(20, 150)) @(posedge clock);
         pop_hold <= 1'b0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty message, invalid bytes, block-boundary lengths.
      send_item(8'h00, 1'b0, 1'b1, 1'b0);        // empty message digest
      send_item(8'hff, 1'b0, 1'b0, 1'b0);        // ignored item
      send_item(8'h00, 1'b1, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1, 1'b0);        // byte riding on last
      send_item(8'h5a, 1'b0, 1'b1, 1'b0);        // empty message again
      send_item(8'haa, 1'b1, 1'b0, 1'b0);
      send_item(8'h55, 1'b1, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1, 1'b0);
      // Pause until all digests are out.
      push <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      send_message(55, 1'b0, 1'b0);              // longest one-block pad
      send_message(56, 1'b0, 1'b0);              // length spills to 2nd block
      send_message(64, 1'b0, 1'b0);              // exact block

      // Random messages, mostly short, a few spanning blocks.
      n = 0;
      while (n < 60) begin
         int len;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 80)
                                           : $urandom_range(0, 12);
         send_message(len, 1'b1, 1'b1);
         n += len + 1;
      end

      push <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
